/* src/form_query_decoder_top_assert.svh */
// Assertion macros used by the checker file.
`ifndef FORM_QUERY_DECODER_TOP_ASSERT_SVH
`define FORM_QUERY_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FQD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fqd: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define FQD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fqd: next-cycle check failed");

`endif

/* src/fqd_pkg.sv */
package fqd_pkg;

    localparam logic [7:0] C_PLUS    = 8'h2B;
    localparam logic [7:0] C_MINUS   = 8'h2D;
    localparam logic [7:0] C_PERCENT = 8'h25;
    localparam logic [7:0] C_AMP     = 8'h26;
    localparam logic [7:0] C_EQUALS  = 8'h3D;
    localparam logic [7:0] C_CR      = 8'h0D;
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_NUL     = 8'h00;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       in_value_part;
        logic       pair_end;
        logic       pair_drop;
        logic       query_end;
    } t_result;

endpackage

/* src/form_query_decoder_top.sv */
// channel | direction | handshake             | beat payload
// in      | input     | i_in_valid/o_in_stall | i_in_byte, i_in_last
// out     | output    | o_out_valid/i_out_stall| byte, value flag, pair/query marks
//
// One beat in per cycle while o_in_stall is low, one result (or none) per beat.
// An input register and a result register stand around the mode machine.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to token start. A stalled result holds; the input register keeps
// accepting as long as the result register drains or is empty.
module form_query_decoder_top
    import fqd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_byte_valid,
    output logic [7:0] o_out_byte,
    output logic       o_in_value_part,
    output logic       o_pair_end,
    output logic       o_pair_drop,
    output logic       o_query_end
);

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    logic       r_out_valid;
    t_result    r_res;

    logic       advance;
    logic       in_acc;
    t_result    res;
    logic       has_res;

    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign in_acc     = i_in_valid && !o_in_stall;

    fqd_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_byte    (r_s1_byte),
        .i_last    (r_s1_last),
        .o_res     (res),
        .o_has_res (has_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
        if (in_acc) begin
            r_s1_byte <= i_in_byte;
            r_s1_last <= i_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= has_res;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_valid    = r_res.byte_valid;
    assign o_out_byte      = r_res.out_byte;
    assign o_in_value_part = r_res.in_value_part;
    assign o_pair_end      = r_res.pair_end;
    assign o_pair_drop     = r_res.pair_drop;
    assign o_query_end     = r_res.query_end;

endmodule

/* src/fqd_hex.sv */
module fqd_hex
    import fqd_pkg::*;
(
    input  logic [7:0] i_first,
    input  logic [7:0] i_second,
    output logic [7:0] o_value
);

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
            || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

    logic       a_blank;
    logic       a_hex;
    logic       b_hex;
    logic [3:0] a_val;
    logic [3:0] b_val;

    assign a_blank = (i_first == C_SPACE) || (i_first >= 8'h09 && i_first <= 8'h0D);
    assign a_hex   = is_hex(i_first);
    assign b_hex   = is_hex(i_second);
    assign a_val   = hex_val(i_first);
    assign b_val   = hex_val(i_second);

    // strtol-style read of two characters
    always_comb begin
        o_value = 8'h00;
        if (a_blank || i_first == C_PLUS) begin
            o_value = b_hex ? {4'h0, b_val} : 8'h00;
        end else if (i_first == C_MINUS) begin
            o_value = b_hex ? (8'h00 - {4'h0, b_val}) : 8'h00;
        end else if (a_hex) begin
            o_value = b_hex ? {a_val, b_val} : {4'h0, a_val};
        end
    end

endmodule

/* src/fqd_parse.sv */
module fqd_parse
    import fqd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_result    o_res,
    output logic       o_has_res
);

    typedef enum logic [2:0] {
        M_START = 3'd0,
        M_NAME  = 3'd1,
        M_VALUE = 3'd2,
        M_HEX1  = 3'd3,
        M_HEX2  = 3'd4,
        M_ENDED = 3'd5
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [7:0] r_first_hex, n_first_hex;
    logic [7:0] hex_value;

    logic       valid, vpart, pend, pdrop, qend;
    logic [7:0] ob;
    t_mode      body_mode;

    fqd_hex u_hex (
        .i_first  (r_first_hex),
        .i_second (i_byte),
        .o_value  (hex_value)
    );

    always_comb begin
        valid       = 1'b0;
        vpart       = 1'b0;
        pend        = 1'b0;
        pdrop       = 1'b0;
        qend        = 1'b0;
        ob          = 8'h00;
        n_mode      = r_mode;
        n_first_hex = r_first_hex;
        body_mode   = r_mode;

        if (r_mode == M_ENDED) begin
            if (i_last) begin
                qend   = 1'b1;
                n_mode = M_START;
            end
        end else if (i_byte == C_NUL || i_byte == C_AMP) begin
            pdrop  = (r_mode == M_NAME);
            pend   = (r_mode == M_VALUE) || (r_mode == M_HEX1) || (r_mode == M_HEX2);
            qend   = i_last;
            n_mode = (i_byte == C_NUL && !i_last) ? M_ENDED : M_START;
        end else begin
            unique case (r_mode)
                M_VALUE: begin
                    if (i_byte == C_PLUS) begin
                        valid = 1'b1;
                        vpart = 1'b1;
                        ob    = C_SPACE;
                    end else if (i_byte == C_PERCENT) begin
                        body_mode = M_HEX1;
                    end else if (i_byte != C_CR) begin
                        valid = 1'b1;
                        vpart = 1'b1;
                        ob    = i_byte;
                    end
                end
                M_HEX1: begin
                    n_first_hex = i_byte;
                    body_mode   = M_HEX2;
                end
                M_HEX2: begin
                    if (hex_value != C_CR) begin
                        valid = 1'b1;
                        vpart = 1'b1;
                        ob    = hex_value;
                    end
                    body_mode = M_VALUE;
                end
                default: begin
                    // token start, name, and unused codes
                    if (i_byte == C_EQUALS) begin
                        body_mode = M_VALUE;
                    end else begin
                        valid     = 1'b1;
                        ob        = i_byte;
                        body_mode = M_NAME;
                    end
                end
            endcase
            n_mode = body_mode;
            // final byte closes the token in the mode it leaves behind
            if (i_last) begin
                pdrop  = (body_mode == M_NAME);
                pend   = (body_mode == M_VALUE) || (body_mode == M_HEX1)
                      || (body_mode == M_HEX2);
                qend   = 1'b1;
                n_mode = M_START;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_START;
            r_first_hex <= 8'h00;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_first_hex <= n_first_hex;
        end
    end

    assign o_res.byte_valid    = valid;
    assign o_res.out_byte      = ob;
    assign o_res.in_value_part = vpart;
    assign o_res.pair_end      = pend;
    assign o_res.pair_drop     = pdrop;
    assign o_res.query_end     = qend;
    assign o_has_res           = valid || pend || pdrop || qend;

endmodule

/* src/fqd_checker.sv */
`include "form_query_decoder_top_assert.svh"

module fqd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_in_byte,
    input logic       i_in_last,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_byte_valid,
    input logic [7:0] o_out_byte,
    input logic       o_in_value_part,
    input logic       o_pair_end,
    input logic       o_pair_drop,
    input logic       o_query_end
);

    // a beat with no byte carries a clean zero payload
    `FQD_ASSERT_NOW(a_idle_byte_zero, i_clk, i_rst_n, o_out_valid && !o_byte_valid, o_out_byte == 8'h00 && !o_in_value_part)

    // a token closes either kept or dropped, never both
    `FQD_ASSERT_NOW(a_end_excl, i_clk, i_rst_n, o_out_valid, !(o_pair_end && o_pair_drop))

    // no empty results
    `FQD_ASSERT_NOW(a_no_empty, i_clk, i_rst_n, o_out_valid, o_byte_valid || o_pair_end || o_pair_drop || o_query_end)

    // stalled result holds
    `FQD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_byte) && $stable(o_query_end))

    // stalled input beat holds
    `FQD_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall, i_in_valid && $stable(i_in_byte) && $stable(i_in_last))

endmodule

bind form_query_decoder_top fqd_checker u_fqd_checker (.*);
